### sv/wrs_pkg.sv
// shared types and constants for the welford running statistics core
// no dependencies; used by the controller, datapath, divider and top level

package wrs_pkg;

  // signed difference (x << 16) - mean, wide enough for a 24-bit sample
  localparam int DIFF_W        = 42;
  localparam int FRAC_SHIFT    = 16;
  localparam int MEAN_W        = 32;
  localparam int DEV_W         = 56;
  localparam int DVD_W         = 56;
  localparam int VAR_W         = 31;
  localparam int STD_W         = 16;
  localparam int OUT_COUNT_W   = 24;

  // shared divider iteration counts
  localparam int ITER_W         = 6;
  localparam int MEAN_DIV_ITERS = DIFF_W;
  localparam int VAR_DIV_ITERS  = DVD_W;

  // product of two difference magnitudes, split over the second operand
  localparam int MUL_SPLIT  = 21;
  localparam int PROD_W     = DIFF_W + MUL_SPLIT;
  localparam int ACC_W      = 2 * DIFF_W;
  localparam int PROD_SHIFT = 32;
  localparam int ADD_W      = ACC_W - PROD_SHIFT;

  // digit-by-digit square root
  localparam int SQRT_W     = 32;
  localparam int SQRT_CNT_W = 5;
  localparam int SQRT_ITERS = 16;
  localparam logic [SQRT_W-1:0] SQRT_TOP = SQRT_W'(32'h4000_0000);

  localparam logic [VAR_W-1:0] VAR_MAX = VAR_W'(32'h4000_0000);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN_DIV,
    S_MEAN_WAIT,
    S_MEAN_UPD,
    S_DIFF2,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_SUM,
    S_DEV_UPD,
    S_VAR_DIV,
    S_VAR_WAIT,
    S_VAR_SAT,
    S_SQRT,
    S_SQRT_WAIT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic take_sample;
    logic div_mean;
    logic div_var;
    logic mean_update;
    logic diff2_load;
    logic mul_lo;
    logic mul_hi;
    logic mul_sum;
    logic dev_update;
    logic var_sat;
    logic sqrt_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic div_busy;
    logic sqrt_busy;
  } status_t;

endpackage

### sv/wrs_channels.sv
// valid/ready channel interfaces for the welford running statistics core
// depends on nothing; the sample width follows the interface parameter

interface wrs_sample_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wrs_stats_if ();
  logic        valid;
  logic        ready;
  logic [31:0] mean;
  logic [30:0] variance;
  logic [15:0] std_dev;
  logic [23:0] sample_count;
  logic        count_full;

  modport source (output valid, output mean, output variance, output std_dev,
                  output sample_count, output count_full, input ready);
  modport sink   (input valid, input mean, input variance, input std_dev,
                  input sample_count, input count_full, output ready);
endinterface

### sv/wrs_div.sv
// restoring divider, one quotient bit per cycle, shared by mean and variance
// depends on wrs_pkg

module wrs_div #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [wrs_pkg::DVD_W-1:0]        dividend,
  input  logic [COUNT_WIDTH-1:0]           divisor,
  input  logic [wrs_pkg::ITER_W-1:0]       iters,
  output logic [wrs_pkg::DVD_W-1:0]        quotient,
  output logic                             busy
);

  localparam int DW = wrs_pkg::DVD_W;
  localparam int IW = wrs_pkg::ITER_W;

  logic [DW-1:0]          dvd;
  logic [DW-1:0]          quot;
  logic [COUNT_WIDTH-1:0] rem;
  logic [IW-1:0]          cnt;
  logic [COUNT_WIDTH:0]   shifted;
  logic [COUNT_WIDTH+1:0] trial;
  logic                   ge;

  assign shifted  = {rem, dvd[DW-1]};
  assign trial    = {1'b0, shifted} - {2'b00, divisor};
  assign ge       = ~trial[COUNT_WIDTH+1];
  assign quotient = quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= iters;
    end else if (busy) begin
      cnt <= cnt - IW'(1);
      if (cnt == IW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      quot <= '0;
      rem  <= '0;
    end else if (busy) begin
      dvd  <= dvd << 1;
      quot <= {quot[DW-2:0], ge};
      rem  <= ge ? trial[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
    end
  end

endmodule

### sv/wrs_dp.sv
// datapath: count, mean and deviation sum, split multiplier, square root,
// output register; depends on wrs_pkg and wrs_div

module wrs_dp #(
  parameter int COUNT_WIDTH  = 24,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  wrs_pkg::cmd_t                       cmd,
  output wrs_pkg::status_t                    status,
  input  logic [SAMPLE_WIDTH-1:0]             sample,
  output logic [wrs_pkg::MEAN_W-1:0]          mean,
  output logic [wrs_pkg::VAR_W-1:0]           variance,
  output logic [wrs_pkg::STD_W-1:0]           std_dev,
  output logic [wrs_pkg::OUT_COUNT_W-1:0]     sample_count,
  output logic                                count_full
);

  localparam int DW  = wrs_pkg::DIFF_W;
  localparam int MW  = wrs_pkg::MEAN_W;
  localparam int EW  = wrs_pkg::DEV_W;
  localparam int VW  = wrs_pkg::VAR_W;
  localparam int QW  = wrs_pkg::DVD_W;
  localparam int SPL = wrs_pkg::MUL_SPLIT;
  localparam int AW  = wrs_pkg::ACC_W;
  localparam int SQW = wrs_pkg::SQRT_W;
  localparam int SCW = wrs_pkg::SQRT_CNT_W;

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
    mag = v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

  // architectural state
  logic [COUNT_WIDTH-1:0] count;
  logic [MW-1:0]          run_mean;
  logic [EW-1:0]          dev_sum;

  // per-item working registers
  logic [DW-1:0]  xs;
  logic [DW-1:0]  diff1;
  logic [DW-1:0]  mag_a;
  logic [DW-1:0]  mag_b;
  logic           same_sign;
  logic           full_item;
  logic [wrs_pkg::PROD_W-1:0] prod;
  logic [AW-1:0]  acc;
  logic [VW-1:0]  var_reg;

  logic [SQW-1:0] sq_v;
  logic [SQW-1:0] sq_res;
  logic [SQW-1:0] sq_bit;
  logic [SCW-1:0] sq_cnt;
  logic           sq_busy;

  // combinational helpers
  logic [DW-1:0]  xs_c;
  logic [DW-1:0]  mean_ext;
  logic [DW-1:0]  diff2_c;
  logic           full_c;
  logic [DW:0]    q_mag;
  logic [DW:0]    q_signed;
  logic [DW+1:0]  mean_sum;
  logic [DW+1-(MW-1):0] mean_top;
  logic [MW-1:0]  mean_next;
  logic [wrs_pkg::ADD_W-1:0] dev_add;
  logic [EW:0]    dev_s;
  logic [SQW-1:0] sq_trial;

  logic                      div_start;
  logic [QW-1:0]             div_dividend;
  logic [wrs_pkg::ITER_W-1:0] div_iters;
  logic [QW-1:0]             quot;
  logic                      div_busy;

  assign xs_c = {{(DW-SAMPLE_WIDTH-wrs_pkg::FRAC_SHIFT){sample[SAMPLE_WIDTH-1]}},
                 sample, {wrs_pkg::FRAC_SHIFT{1'b0}}};
  assign mean_ext = {{(DW-MW){run_mean[MW-1]}}, run_mean};
  assign diff2_c  = xs - mean_ext;
  assign full_c   = (count == {COUNT_WIDTH{1'b1}});

  // mean += diff1 / count, quotient truncated toward zero, then saturated
  assign q_mag    = {1'b0, quot[DW-1:0]};
  assign q_signed = diff1[DW-1] ? (~q_mag + (DW+1)'(1)) : q_mag;
  assign mean_sum = {q_signed[DW], q_signed} + {{2{run_mean[MW-1]}}, mean_ext};
  assign mean_top = mean_sum[DW+1:MW-1];

  always_comb begin
    if ((&mean_top) || (~|mean_top)) begin
      mean_next = mean_sum[MW-1:0];
    end else if (mean_sum[DW+1]) begin
      mean_next = {1'b1, {(MW-1){1'b0}}};
    end else begin
      mean_next = {1'b0, {(MW-1){1'b1}}};
    end
  end

  // product >> 32 added only when both differences share a sign
  assign dev_add  = same_sign ? acc[AW-1:wrs_pkg::PROD_SHIFT] : '0;
  assign dev_s    = {1'b0, dev_sum} + (EW+1)'(dev_add);
  assign sq_trial = sq_res + sq_bit;

  assign div_start    = cmd.div_mean | cmd.div_var;
  assign div_dividend = cmd.div_mean ? {mag(diff1), {(QW-DW){1'b0}}} : QW'(dev_sum);
  assign div_iters    = cmd.div_mean ? wrs_pkg::ITER_W'(wrs_pkg::MEAN_DIV_ITERS)
                                     : wrs_pkg::ITER_W'(wrs_pkg::VAR_DIV_ITERS);

  wrs_div #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count),
    .iters    (div_iters),
    .quotient (quot),
    .busy     (div_busy)
  );

  assign status.full      = full_c;
  assign status.div_busy  = div_busy;
  assign status.sqrt_busy = sq_busy;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      run_mean <= '0;
      dev_sum  <= '0;
      sq_busy  <= 1'b0;
      sq_cnt   <= '0;
    end else begin
      if (cmd.take_sample && !full_c) begin
        count <= count + COUNT_WIDTH'(1);
      end
      if (cmd.mean_update) begin
        run_mean <= mean_next;
      end
      if (cmd.dev_update) begin
        dev_sum <= dev_s[EW] ? {EW{1'b1}} : dev_s[EW-1:0];
      end
      if (cmd.sqrt_start) begin
        sq_busy <= 1'b1;
        sq_cnt  <= SCW'(wrs_pkg::SQRT_ITERS);
      end else if (sq_busy) begin
        sq_cnt <= sq_cnt - SCW'(1);
        if (sq_cnt == SCW'(1)) begin
          sq_busy <= 1'b0;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      xs        <= xs_c;
      diff1     <= xs_c - mean_ext;
      full_item <= full_c;
    end
    if (cmd.diff2_load) begin
      mag_a     <= mag(diff1);
      mag_b     <= mag(diff2_c);
      same_sign <= (diff1[DW-1] == diff2_c[DW-1]);
    end
    if (cmd.mul_lo) begin
      prod <= mag_a * mag_b[SPL-1:0];
    end
    if (cmd.mul_hi) begin
      acc  <= AW'(prod);
      prod <= mag_a * mag_b[DW-1:SPL];
    end
    if (cmd.mul_sum) begin
      acc <= acc + (AW'(prod) << SPL);
    end
    if (cmd.var_sat) begin
      if ((|quot[QW-1:VW]) || (quot[VW-1:0] > wrs_pkg::VAR_MAX)) begin
        var_reg <= wrs_pkg::VAR_MAX;
      end else begin
        var_reg <= quot[VW-1:0];
      end
    end
    if (cmd.sqrt_start) begin
      sq_v   <= SQW'(var_reg);
      sq_res <= '0;
      sq_bit <= wrs_pkg::SQRT_TOP;
    end else if (sq_busy) begin
      if (sq_v >= sq_trial) begin
        sq_v   <= sq_v - sq_trial;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
    if (cmd.load_out) begin
      mean         <= run_mean;
      variance     <= var_reg;
      std_dev      <= sq_res[wrs_pkg::STD_W-1:0];
      sample_count <= wrs_pkg::OUT_COUNT_W'(count);
      count_full   <= full_item;
    end
  end

endmodule

### sv/wrs_ctrl.sv
// controller state machine: sequences one item through the datapath and
// owns the handshakes; depends on wrs_pkg

module wrs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  wrs_pkg::status_t  status,
  output wrs_pkg::cmd_t     cmd
);

  wrs_pkg::state_t state;
  wrs_pkg::state_t state_next;
  logic            out_free;

  assign out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wrs_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wrs_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = status.full ? wrs_pkg::S_VAR_DIV : wrs_pkg::S_MEAN_DIV;
        end
      end
      wrs_pkg::S_MEAN_DIV:  state_next = wrs_pkg::S_MEAN_WAIT;
      wrs_pkg::S_MEAN_WAIT: begin
        if (!status.div_busy) begin
          state_next = wrs_pkg::S_MEAN_UPD;
        end
      end
      wrs_pkg::S_MEAN_UPD:  state_next = wrs_pkg::S_DIFF2;
      wrs_pkg::S_DIFF2:     state_next = wrs_pkg::S_MUL_LO;
      wrs_pkg::S_MUL_LO:    state_next = wrs_pkg::S_MUL_HI;
      wrs_pkg::S_MUL_HI:    state_next = wrs_pkg::S_MUL_SUM;
      wrs_pkg::S_MUL_SUM:   state_next = wrs_pkg::S_DEV_UPD;
      wrs_pkg::S_DEV_UPD:   state_next = wrs_pkg::S_VAR_DIV;
      wrs_pkg::S_VAR_DIV:   state_next = wrs_pkg::S_VAR_WAIT;
      wrs_pkg::S_VAR_WAIT: begin
        if (!status.div_busy) begin
          state_next = wrs_pkg::S_VAR_SAT;
        end
      end
      wrs_pkg::S_VAR_SAT:   state_next = wrs_pkg::S_SQRT;
      wrs_pkg::S_SQRT:      state_next = wrs_pkg::S_SQRT_WAIT;
      wrs_pkg::S_SQRT_WAIT: begin
        if (!status.sqrt_busy) begin
          state_next = wrs_pkg::S_RESULT;
        end
      end
      wrs_pkg::S_RESULT: begin
        if (out_free) begin
          state_next = wrs_pkg::S_IDLE;
        end
      end
      default:              state_next = wrs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.take_sample = (state == wrs_pkg::S_IDLE) & in_valid;
    cmd.div_mean    = (state == wrs_pkg::S_MEAN_DIV);
    cmd.mean_update = (state == wrs_pkg::S_MEAN_UPD);
    cmd.diff2_load  = (state == wrs_pkg::S_DIFF2);
    cmd.mul_lo      = (state == wrs_pkg::S_MUL_LO);
    cmd.mul_hi      = (state == wrs_pkg::S_MUL_HI);
    cmd.mul_sum     = (state == wrs_pkg::S_MUL_SUM);
    cmd.dev_update  = (state == wrs_pkg::S_DEV_UPD);
    cmd.div_var     = (state == wrs_pkg::S_VAR_DIV);
    cmd.var_sat     = (state == wrs_pkg::S_VAR_SAT);
    cmd.sqrt_start  = (state == wrs_pkg::S_SQRT);
    cmd.load_out    = (state == wrs_pkg::S_RESULT) & out_free;
    in_ready        = (state == wrs_pkg::S_IDLE);
  end

endmodule

### sv/welford_running_stats_core.sv
// top level of the welford running statistics core
// depends on wrs_pkg, wrs_channels (interfaces), wrs_ctrl, wrs_dp, wrs_div
//
// usage
//   sample_ch carries one signed Q7.8 sample per item; stats_ch returns one
//   item per sample: running mean (2^-24), population variance (2^-16,
//   saturating at 2^30), floor square root as standard deviation (2^-8),
//   the sample count and a flag that the count was already full
//   both channels are valid/ready; an item moves when both are high
// sequence
//   one item at a time; an accepted sample passes the shared divider for the
//   mean update, the split multiply, the same divider again for the variance
//   and the square root, with control steps between, before it reaches the
//   output register
//   once the count is full the mean and deviation steps are skipped
//   the bit-serial divider runs twice per sample, once if the count is full
// reset and stall
//   rst (synchronous) clears count, mean and deviation sum to zero
//   a finished result waits in the output register; the next sample is
//   taken meanwhile and only its own result waits for the register to free

module welford_running_stats_core #(
  parameter int COUNT_WIDTH  = 24,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  wrs_sample_if.sink   sample_ch,
  wrs_stats_if.source  stats_ch
);

  wrs_pkg::cmd_t    cmd;
  wrs_pkg::status_t status;

  // controller: sequencing and handshakes
  wrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .out_valid (stats_ch.valid),
    .out_ready (stats_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: welford update, variance division, square root, output reg
  wrs_dp #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample       (sample_ch.sample),
    .mean         (stats_ch.mean),
    .variance     (stats_ch.variance),
    .std_dev      (stats_ch.std_dev),
    .sample_count (stats_ch.sample_count),
    .count_full   (stats_ch.count_full)
  );

  // variance never exceeds its saturation value
  a_var_bound: assert property (@(posedge clk) disable iff (rst)
    stats_ch.valid |-> (stats_ch.variance <= wrs_pkg::VAR_MAX))
    else $error("variance above saturation value");

  // standard deviation is the floor square root of the reported variance
  a_sqrt_floor: assert property (@(posedge clk) disable iff (rst)
    stats_ch.valid |->
      ((33'(stats_ch.std_dev) * 33'(stats_ch.std_dev) <= 33'(stats_ch.variance)) &&
       ((33'(stats_ch.std_dev) + 33'd1) * (33'(stats_ch.std_dev) + 33'd1) >
        33'(stats_ch.variance))))
    else $error("std_dev is not the floor square root of variance");

  // the block is busy right after taking a sample
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (sample_ch.valid && sample_ch.ready) |=> !sample_ch.ready)
    else $error("sample taken while an item is in work");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench for welford_running_stats_core: signed samples in, running statistics out
// depends on wrs_pkg, the wrs_channels interfaces and the core; self-checking,
// with a fixed-point model of the welford update that predicts every stats item

module testbench;

  // model limits, at the widths the core uses
  localparam logic [23:0] CNT_MAX  = 24'hFF_FFFF;
  localparam logic [63:0] DEV_MAX  = 64'h00FF_FFFF_FFFF_FFFF;
  localparam longint      MEAN_HI  = 64'sd2147483647;
  localparam longint      MEAN_LO  = -64'sd2147483648;
  localparam int          TAIL_CYC = 300;
  localparam int          DRAIN_CYC = 5000;

  typedef struct {
    logic [31:0] mean;
    logic [30:0] variance;
    logic [15:0] std_dev;
    logic [23:0] sample_count;
    logic        count_full;
  } stats_item_t;

  logic clk;
  logic rst;

  wrs_sample_if #(.SAMPLE_WIDTH(16)) sample_ch ();
  wrs_stats_if                       stats_ch ();

  welford_running_stats_core #(
    .COUNT_WIDTH  (24),
    .SAMPLE_WIDTH (16)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .stats_ch  (stats_ch)
  );

  // samples waiting to be offered and stats items still owed by the core
  logic [15:0]  pending_samples[$];
  stats_item_t  expected_stats[$];
  stats_item_t  oldest_stats;

  // model copy of the core state
  logic [23:0]        samples_held;
  logic signed [31:0] mean_acc;
  logic [55:0]        dev_sum_acc;

  int error_count;
  int samples_taken;
  int results_seen;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    error_count++;
  endtask

  // floor square root, one result bit per step from the top
  function automatic logic [15:0] floor_sqrt(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= v) root = trial;
    end
    return root[15:0];
  endfunction

  // one welford step on an accepted sample unless the count is full, then queue the stats item it owes
  task automatic welford_update(input logic signed [15:0] x);
    longint       xs;
    longint       n;
    longint       d1;
    longint       d2;
    longint       nm;
    logic [63:0]  mag1;
    logic [63:0]  mag2;
    logic [127:0] prod;
    logic [63:0]  dev_add;
    logic [63:0]  dev_next;
    logic [63:0]  var_q;
    stats_item_t  item;
    logic         full;
    full  = (samples_held == CNT_MAX);
    xs    = longint'(x) * 65536;
    var_q = '0;
    if (!full) begin
      samples_held = samples_held + 24'd1;
      n  = samples_held;
      d1 = xs - longint'(mean_acc);
      // signed division truncates toward zero, as the core's divider does
      nm = longint'(mean_acc) + d1 / n;
      if (nm > MEAN_HI) nm = MEAN_HI;
      if (nm < MEAN_LO) nm = MEAN_LO;
      mean_acc = nm[31:0];
      d2 = xs - nm;
      dev_add = '0;
      // only same-signed differences add to the deviation sum
      if ((d1 >= 0 && d2 >= 0) || (d1 <= 0 && d2 <= 0)) begin
        mag1 = (d1 < 0) ? -d1 : d1;
        mag2 = (d2 < 0) ? -d2 : d2;
        prod = {64'd0, mag1} * {64'd0, mag2};
        if (prod[127:32] > 96'(DEV_MAX)) dev_add = DEV_MAX;
        else dev_add = prod[95:32];
      end
      dev_next    = {8'd0, dev_sum_acc} + dev_add;
      dev_sum_acc = (dev_next > DEV_MAX) ? DEV_MAX[55:0] : dev_next[55:0];
    end
    if (samples_held != 0) begin
      var_q = {8'd0, dev_sum_acc} / {40'd0, samples_held};
      if (var_q > 64'(wrs_pkg::VAR_MAX)) var_q = 64'(wrs_pkg::VAR_MAX);
    end
    item.mean         = mean_acc;
    item.variance     = var_q[30:0];
    item.std_dev      = floor_sqrt(var_q);
    item.sample_count = samples_held;
    item.count_full   = full;
    expected_stats.push_back(item);
  endtask

  // random pause at about 6 in 100 calls, none in a stretch mid-run
  function automatic bit take_break(input int progress);
    if (progress >= 150 && progress < 250) return 1'b0;
    return $urandom_range(99) < 6;
  endfunction

  // sample driver: predicts on acceptance, then offers the next pending sample
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        welford_update(sample_ch.sample);
        samples_taken++;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (pending_samples.size() != 0 && !take_break(samples_taken)) begin
          sample_ch.sample <= pending_samples.pop_front();
          sample_ch.valid  <= 1'b1;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // stats monitor: each accepted item is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      stats_ch.ready <= 1'b0;
    end else begin
      if (stats_ch.valid && stats_ch.ready) begin
        results_seen++;
        if (expected_stats.size() == 0) begin
          report_mismatch($sformatf("stats item %0d with no sample behind it", results_seen));
        end else begin
          oldest_stats = expected_stats.pop_front();
          if (stats_ch.mean !== oldest_stats.mean)
            report_mismatch($sformatf("item %0d mean %0h, want %0h", results_seen,
                                      stats_ch.mean, oldest_stats.mean));
          if (stats_ch.variance !== oldest_stats.variance)
            report_mismatch($sformatf("item %0d variance %0h, want %0h", results_seen,
                                      stats_ch.variance, oldest_stats.variance));
          if (stats_ch.std_dev !== oldest_stats.std_dev)
            report_mismatch($sformatf("item %0d std_dev %0h, want %0h", results_seen,
                                      stats_ch.std_dev, oldest_stats.std_dev));
          if (stats_ch.sample_count !== oldest_stats.sample_count)
            report_mismatch($sformatf("item %0d sample_count %0d, want %0d", results_seen,
                                      stats_ch.sample_count, oldest_stats.sample_count));
          if (stats_ch.count_full !== oldest_stats.count_full)
            report_mismatch($sformatf("item %0d count_full %0b, want %0b", results_seen,
                                      stats_ch.count_full, oldest_stats.count_full));
        end
      end
      stats_ch.ready <= !take_break(results_seen);
    end
  end

  // stimulus, reset and end of run
  initial begin
    int drained;
    int pick;
    rst              = 1'b1;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    stats_ch.ready   = 1'b0;
    samples_held     = '0;
    mean_acc         = '0;
    dev_sum_acc      = '0;
    error_count      = 0;
    samples_taken    = 0;
    results_seen     = 0;

    // directed: a zero first, then the two extremes in turn to drive the
    // variance toward its ceiling, then small and patterned values
    pending_samples.push_back(16'h0000);
    repeat (4) begin
      pending_samples.push_back(16'h7FFF);
      pending_samples.push_back(16'h8000);
    end
    pending_samples.push_back(16'hFFFF);
    pending_samples.push_back(16'h0001);
    pending_samples.push_back(16'h0100);
    pending_samples.push_back(16'hFF00);
    pending_samples.push_back(16'h5555);
    pending_samples.push_back(16'hAAAA);
    pending_samples.push_back(16'h8001);
    pending_samples.push_back(16'h7FFE);
    repeat (3) pending_samples.push_back(16'h0000);
    pending_samples.push_back(16'h7FFF);

    // random: mostly full range, some hugging the extremes, some near zero
    repeat (400) begin
      pick = $urandom_range(99);
      if (pick < 70)
        pending_samples.push_back(16'($urandom_range(16'hFFFF)));
      else if (pick < 85)
        pending_samples.push_back($urandom_range(1) ? 16'($urandom_range(16'h7FFF, 16'h7F00))
                                                    : 16'($urandom_range(16'h80FF, 16'h8000)));
      else
        pending_samples.push_back(16'($signed(10'($urandom_range(10'h3FF)))));
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // all samples offered and taken
    while (pending_samples.size() != 0 || sample_ch.valid) @(posedge clk);

    // every owed item back, then a quiet tail to catch anything extra
    drained = 0;
    while (expected_stats.size() != 0 && drained < DRAIN_CYC) begin
      @(posedge clk);
      drained++;
    end
    repeat (TAIL_CYC) @(posedge clk);
    if (expected_stats.size() != 0)
      report_mismatch($sformatf("%0d stats items never arrived", expected_stats.size()));

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog: ample for ~425 samples with stalls
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
sv/wrs_pkg.sv
sv/wrs_channels.sv
sv/wrs_div.sv
sv/wrs_dp.sv
sv/wrs_ctrl.sv
sv/welford_running_stats_core.sv
tb/sv/testbench.sv
